### rtl/mh2_pkg.sv
// Package for the MurmurHash2 bucket selector: constants, codes, shared types
// and the small arithmetic helpers of the hash rounds.
// No dependencies; imported by every module of the block.
package mh2_pkg;

  // Hash constants
  localparam logic [31:0] MixMul     = 32'h5bd1e995;
  localparam int unsigned MixShift   = 24;
  localparam int unsigned FinShift1  = 13;
  localparam int unsigned FinShift2  = 15;

  // Configuration reset values
  localparam logic [31:0] SeedReset   = 32'd272727;
  localparam logic [31:0] BucketReset = 32'd1024;

  // Divider sizing
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HASH_SEED    = 1'd0,
    CFG_BUCKET_COUNT = 1'd1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_FIN,
    ST_DIV,
    ST_HOLD
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_word;  // transaction accepted: seed and first mix step
    logic mix2;       // second mix step of a full word
    logic fin;        // finalize and start the modulo
    logic out_load;   // move remainder into the output register
  } mh2_cmd_t;

  // Truncated 32-bit product with the mix constant
  function automatic logic [31:0] mul_m(input logic [31:0] x);
    logic [31:0] p;
    p = x * MixMul;
    return p;
  endfunction

  // Mask of the valid tail bytes for a count of 0 to 3
  function automatic logic [31:0] tail_mask(input logic [1:0] n);
    logic [31:0] m;
    case (n)
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

### rtl/mh2_div.sv
// Restoring divider returning the remainder, one quotient bit per cycle.
// Depends on mh2_pkg; instantiated by mh2_dp.
module mh2_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] rem_o
);
  import mh2_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        dvd_q, dvd_d;
  logic [32:0]        trial;
  logic [32:0]        diff;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_q, dvd_q[31]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[31:0] : trial[31:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

### rtl/mh2_dp.sv
// Datapath of the hash: configuration registers, running hash, mix and
// finalize steps, modulo divider and output payload register.
// Depends on mh2_pkg and mh2_div.
module mh2_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [mh2_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]             cfg_data_i,
  input  logic [31:0]             word_data_i,
  input  logic [2:0]              bytes_in_word_i,
  input  logic                    last_word_i,
  input  logic [31:0]             total_length_i,
  input  mh2_pkg::mh2_cmd_t       cmd_i,
  output logic                    div_busy_o,
  output logic [31:0]             bucket_index_o
);
  import mh2_pkg::*;

  logic [31:0] hash_seed_q;
  logic [31:0] bucket_count_q;
  logic        kip_q;
  logic [31:0] h_q, h_d;
  logic [31:0] k1_q;
  logic [31:0] hm_q;
  logic [31:0] bucket_index_q;
  logic [31:0] h_src;
  logic [31:0] tail_bits;
  logic [31:0] k_mid;
  logic [31:0] fin_prod;
  logic [31:0] fin_val;
  logic [31:0] rem;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_seed_q    <= SeedReset;
      bucket_count_q <= BucketReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HASH_SEED:    hash_seed_q    <= cfg_data_i;
        CFG_BUCKET_COUNT: bucket_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Seed on the first word of a key
  assign h_src     = kip_q ? h_q : (hash_seed_q ^ total_length_i);
  assign tail_bits = word_data_i & tail_mask(bytes_in_word_i[1:0]);
  assign k_mid     = k1_q ^ (k1_q >> MixShift);

  // Next running hash
  always_comb begin
    h_d = h_q;
    if (cmd_i.load_word) begin
      if (bytes_in_word_i[2]) begin
        h_d = h_src;
      end else if (bytes_in_word_i[1:0] == 2'd0) begin
        h_d = h_src;
      end else begin
        h_d = mul_m(h_src ^ tail_bits);
      end
    end else if (cmd_i.mix2) begin
      h_d = hm_q ^ mul_m(k_mid);
    end
  end

  // Key tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kip_q <= 1'b0;
    end else if (cmd_i.load_word) begin
      kip_q <= !last_word_i;
    end
  end

  // Hash registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else begin
      h_q <= h_d;
    end
  end

  // First mix step of a full word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      k1_q <= mul_m(word_data_i);
      hm_q <= mul_m(h_src);
    end
  end

  // Finalize into the divider
  assign fin_prod = mul_m(h_q ^ (h_q >> FinShift1));
  assign fin_val  = fin_prod ^ (fin_prod >> FinShift2);

  mh2_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.fin),
    .dividend_i (fin_val),
    .divisor_i  (bucket_count_q),
    .busy_o     (div_busy_o),
    .rem_o      (rem)
  );

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bucket_index_q <= rem;
    end
  end

  assign bucket_index_o = bucket_index_q;

endmodule

### rtl/mh2_ctrl.sv
// Controller of the hash: sequences word mixing, finalize and modulo, and
// owns the input stall and the output valid.
// Depends on mh2_pkg.
module mh2_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              full_word_i,
  input  logic              last_word_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              div_busy_i,
  output mh2_pkg::mh2_cmd_t cmd_o
);
  import mh2_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        last_q;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;
  logic        out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (full_word_i) begin
            state_d = ST_MIX;
          end else if (last_word_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MIX:  state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN:  state_d = ST_DIV;
      ST_DIV: begin
        if (!div_busy_i) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_word = in_valid_i;
      end
      ST_MIX:  cmd_o.mix2 = 1'b1;
      ST_FIN:  cmd_o.fin  = 1'b1;
      ST_DIV:  cmd_o.out_load = !div_busy_i && out_free;
      ST_HOLD: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        last_q <= last_word_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten");

  // Finalize always starts the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> (state_q == ST_DIV) && div_busy_i)
    else $error("divider not started");

  // Second mix step only follows an accepted full word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> $past(in_acc && full_word_i))
    else $error("mix step without full word");

  // Divider never runs while a new word is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !div_busy_i)
    else $error("input accepted during modulo");
`endif

endmodule

### rtl/murmur2_string_hash_bucket.sv
// MurmurHash2 bucket selector: a full word is hashed on acceptance and mixed again in
// ST_MIX, a short word on acceptance only. A last word then passes through ST_FIN, the
// modulo divider in ST_DIV and the output load into the result register; the next word
// is taken only after that load, and later while an earlier result waits stalled.
// Reset clears the key state and output valid and loads hash_seed = 272727,
// bucket_count = 1024.
module murmur2_string_hash_bucket (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mh2_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 word_data_i,
  input  logic [2:0]                  bytes_in_word_i,
  input  logic                        last_word_i,
  input  logic [31:0]                 total_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 bucket_index_o
);
  import mh2_pkg::*;

  mh2_cmd_t cmd;
  logic     div_busy;

  mh2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .full_word_i (bytes_in_word_i[2]),
    .last_word_i (last_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .div_busy_i  (div_busy),
    .cmd_o       (cmd)
  );

  mh2_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .word_data_i     (word_data_i),
    .bytes_in_word_i (bytes_in_word_i),
    .last_word_i     (last_word_i),
    .total_length_i  (total_length_i),
    .cmd_i           (cmd),
    .div_busy_o      (div_busy),
    .bucket_index_o  (bucket_index_o)
  );

endmodule

### tb/murmur2_string_hash_bucket_tb.sv
// Self-checking testbench for murmur2_string_hash_bucket: streams keys word by word, predicts
// each bucket index with a local MurmurHash2 model and compares every output transaction.
// Depends on mh2_pkg (register index codes) and the murmur2_string_hash_bucket RTL.
`timescale 1ns / 1ps

module murmur2_string_hash_bucket_tb;
  import mh2_pkg::*;

  localparam logic [31:0] HASH_MUL     = 32'h5bd1e995;
  localparam logic [31:0] SEED_DEFAULT = 32'd272727;
  localparam logic [31:0] DIV_DEFAULT  = 32'd1024;
  localparam int          SETTLE_CYC   = 48;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          PHASE_WORDS  = 190;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic [31:0] len;
  } key_word_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [31:0]         cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [31:0]         word_data_i     = '0;
  logic [2:0]          bytes_in_word_i = '0;
  logic                last_word_i     = 1'b0;
  logic [31:0]         total_length_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [31:0]         bucket_index_o;

  // Words waiting to be sent, and bucket indexes waiting to come out
  key_word_t   word_backlog[$];
  logic [31:0] bucket_due[$];

  // Local copy of the hash state and the registers
  logic [31:0] hash_acc   = '0;
  logic        key_open   = 1'b0;
  logic [31:0] seed_cfg   = SEED_DEFAULT;
  logic [31:0] bucket_cfg = DIV_DEFAULT;

  int errors     = 0;
  int gap_pct    = 30;
  int stall_pct  = 30;
  bit calm       = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;
  key_word_t   sent_word;
  logic [31:0] want;

  murmur2_string_hash_bucket DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .word_data_i    (word_data_i),
    .bytes_in_word_i(bytes_in_word_i),
    .last_word_i    (last_word_i),
    .total_length_i (total_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bucket_index_o (bucket_index_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Finalization avalanche of the hash
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 13);
    x = x * HASH_MUL;
    x = x ^ (x >> 15);
    return x;
  endfunction

  // Advance the hash by one accepted word; on the last word queue the bucket index
  function automatic void hash_word(input key_word_t kw);
    logic [31:0] k;
    logic [31:0] keep;
    logic [31:0] h;
    if (!key_open) begin
      hash_acc = seed_cfg ^ kw.len;
      key_open = 1'b1;
    end
    if (kw.nbytes >= 3'd4) begin
      k = kw.word * HASH_MUL;
      k = k ^ (k >> 24);
      k = k * HASH_MUL;
      hash_acc = (hash_acc * HASH_MUL) ^ k;
    end else if (kw.nbytes != 3'd0) begin
      keep = 32'hffff_ffff >> (32 - 8 * int'(kw.nbytes));
      hash_acc = hash_acc ^ (kw.word & keep);
      hash_acc = hash_acc * HASH_MUL;
    end
    if (kw.last) begin
      h = avalanche(hash_acc);
      bucket_due.push_back((bucket_cfg != 32'd0) ? h % bucket_cfg : h);
      key_open = 1'b0;
      hash_acc = '0;
    end
  endfunction

  function automatic void queue_word(input logic [31:0] w, input logic [2:0] n,
                                     input logic l, input logic [31:0] len);
    key_word_t kw;
    kw.word   = w;
    kw.nbytes = n;
    kw.last   = l;
    kw.len    = len;
    word_backlog.push_back(kw);
  endfunction

  // Mostly well-formed keys with random content; some keys carry odd byte counts,
  // early last flags or a wrong length
  function automatic void queue_random_keys(input int budget);
    int          queued;
    int          nfull;
    int          i;
    bit          noisy;
    bit          full_tail;
    logic [2:0]  tail_n;
    logic [31:0] klen;
    queued = 0;
    while (queued < budget) begin
      nfull     = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(5);
      noisy     = ($urandom_range(9) == 0);
      full_tail = ($urandom_range(3) == 0);
      tail_n    = full_tail ? 3'(4 + (noisy ? $urandom_range(3) : 0)) : 3'($urandom_range(3));
      klen      = 32'(4 * nfull) + (full_tail ? 32'd4 : 32'(tail_n));
      if ($urandom_range(15) == 0) klen = $urandom;
      for (i = 0; i < nfull; i++) begin
        queue_word($urandom, noisy ? 3'($urandom_range(7)) : 3'd4,
                   noisy && ($urandom_range(7) == 0), klen);
      end
      queue_word($urandom, tail_n, 1'b1, klen);
      queued += nfull + 1;
    end
  endfunction

  // Wait until every word is sent and every index is out, then let the block go quiet
  task automatic settle();
    do @(negedge clk_i);
    while (word_backlog.size() != 0 || in_valid_i || bucket_due.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_HASH_SEED) seed_cfg = val;
    else bucket_cfg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] seed, input logic [31:0] div,
                           input int gap, input int stall);
    write_reg(CFG_HASH_SEED, seed);
    write_reg(CFG_BUCKET_COUNT, div);
    gap_pct   = gap;
    stall_pct = stall;
    @(negedge clk_i);
    queue_random_keys(PHASE_WORDS);
    settle();
  endtask

  // Input driver: hold a stalled transaction, otherwise idle in bursts or present the next word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sent_word = word_backlog.pop_front();
        hash_word(sent_word);
      end
      if (in_valid_i && in_stall_o) begin
        // hold the payload
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (word_backlog.size() != 0 && !calm && $urandom_range(99) < gap_pct) begin
        gap_left = $urandom_range(7, 1) - 1;
        in_valid_i <= 1'b0;
      end else if (word_backlog.size() != 0) begin
        in_valid_i      <= 1'b1;
        word_data_i     <= word_backlog[0].word;
        bytes_in_word_i <= word_backlog[0].nbytes;
        last_word_i     <= word_backlog[0].last;
        total_length_i  <= word_backlog[0].len;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: check each accepted transaction, stall in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (bucket_due.size() == 0) begin
          $display("%0t: bucket_index expected none, actual %h", $time, bucket_index_o);
          errors++;
        end else begin
          want = bucket_due.pop_front();
          if (bucket_index_o !== want) begin
            $display("%0t: bucket_index expected %h, actual %h", $time, want, bucket_index_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(7, 1) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed keys at the reset settings
    queue_word(32'hffff_ffff, 3'd0, 1'b1, 32'd0);           // empty key
    queue_word(32'hffff_ffff, 3'd1, 1'b1, 32'd1);           // tails with junk above
    queue_word(32'hffff_ffff, 3'd2, 1'b1, 32'd2);
    queue_word(32'hffff_ffff, 3'd3, 1'b1, 32'd3);
    queue_word(32'hffff_ffff, 3'd4, 1'b1, 32'd4);           // full word as last
    queue_word(32'h0000_0000, 3'd4, 1'b1, 32'hffff_ffff);
    queue_word(32'hdead_beef, 3'd4, 1'b0, 32'd7);
    queue_word(32'hff12_3456, 3'd3, 1'b1, 32'd7);
    queue_word(32'h0123_4567, 3'd5, 1'b0, 32'd8);           // oversized counts
    queue_word(32'h89ab_cdef, 3'd6, 1'b1, 32'd8);
    queue_word(32'h5555_aaaa, 3'd7, 1'b1, 32'd4);
    queue_word(32'hcafe_f00d, 3'd2, 1'b0, 32'd9);           // short word mid-key
    queue_word(32'h1357_9bdf, 3'd4, 1'b0, 32'd9);
    queue_word(32'h2468_ace0, 3'd1, 1'b1, 32'd9);
    queue_word(32'h7fff_ffff, 3'd4, 1'b0, 32'hffff_ffff);   // length mismatch
    queue_word(32'h8000_0000, 3'd0, 1'b1, 32'hffff_ffff);
    queue_word(32'h0000_0000, 3'd0, 1'b1, 32'd0);
    queue_word(32'h8000_0001, 3'd4, 1'b1, 32'h1234_5678);
    settle();

    // Register sweep: zero divisor, extremes, then random settings
    run_phase(32'd0, 32'd0, 30, 30);
    run_phase(32'hffff_ffff, 32'd1, 10, 50);
    run_phase($urandom, 32'hffff_ffff, 50, 10);
    run_phase($urandom, 32'($urandom_range(100, 2)), 0, 0);
    run_phase($urandom, $urandom, 40, 40);
    run_phase(SEED_DEFAULT, 32'd1 << $urandom_range(31), 20, 20);

    // Last stretch runs without idling on either side
    calm = 1'b1;
    run_phase($urandom, $urandom, 0, 0);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
